// ===== rtl/dqpb_pkg.sv =====
// Shared constants, types and register codes for the DNS query packet builder.
`default_nettype none

package dqpb_pkg;

    // label buffer
    localparam int MAX_LABEL = 58;
    localparam int FILL_W    = $clog2(MAX_LABEL + 1);
    localparam int LBL_AW    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    // fixed packet sections
    localparam int HDR_LEN  = 12;
    localparam int TAIL_LEN = 5;
    localparam int CNT_W    = (FILL_W > 4) ? FILL_W : 4;

    // command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = 2;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // configuration registers
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_QUERY_ID          = 2'd0;
    localparam logic [1:0] REG_RECURSION_DESIRED = 2'd1;
    localparam logic [1:0] REG_QUERY_TYPE        = 2'd2;
    localparam logic [1:0] REG_QUERY_CLASS       = 2'd3;

    localparam logic [15:0] QUERY_ID_RST    = 16'd1234;
    localparam logic        RD_RST          = 1'b1;
    localparam logic [15:0] QUERY_TYPE_RST  = 16'd1;
    localparam logic [15:0] QUERY_CLASS_RST = 16'd1;

    // one unit of work for the back end
    typedef struct packed {
        logic              hdr;
        logic              lbl;
        logic              tail;
        logic              trunc;
        logic [FILL_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic [15:0] query_id;
        logic        recursion_desired;
        logic [15:0] query_type;
        logic [15:0] query_class;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/dqpb_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module dqpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 58
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dqpb_cmd_fifo.sv =====
// Short command queue between the front and back ends.
`default_nettype none

module dqpb_cmd_fifo
    import dqpb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_cmd,
    output logic      empty
);

    cmd_t             mem_reg [CQ_DEPTH];
    logic [CQ_AW-1:0] wptr_reg;
    logic [CQ_AW-1:0] rptr_reg;
    logic [CQ_AW:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full   = (count_reg == (CQ_AW + 1)'(CQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dqpb_front.sv =====
// Front end: takes name characters, buffers labels, issues commands.
`default_nettype none

module dqpb_front
    import dqpb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        name_char,
    input  wire logic              name_end,
    input  wire logic              label_done,
    output logic                   ram_we,
    output logic [LBL_AW-1:0]      ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic                   cq_wr,
    output cmd_t                   cq_cmd,
    input  wire logic              cq_full
);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              header_sent_reg, header_sent_next;
    logic              name_closed_reg, name_closed_next;
    logic              overflow_reg, overflow_next;
    logic              label_busy_reg, label_busy_next;
    logic              accept;
    logic              is_dot;
    logic              fill_zero;

    // hold off everything while the back end still reads the label buffer
    assign full      = cq_full || label_busy_reg;
    assign accept    = push && !full;
    assign is_dot    = (name_char == DOT_CHAR);
    assign fill_zero = (fill_reg == '0);
    assign ram_waddr = fill_reg[LBL_AW-1:0];
    assign ram_wdata = name_char;

    always_comb
    begin
        fill_next        = fill_reg;
        header_sent_next = header_sent_reg;
        name_closed_next = name_closed_reg;
        overflow_next    = overflow_reg;
        label_busy_next  = label_busy_reg;
        ram_we           = 1'b0;
        cq_cmd           = '0;
        cq_cmd.trunc     = overflow_reg;
        cq_cmd.len       = fill_reg;

        if (label_done)
        begin
            label_busy_next = 1'b0;
        end

        if (accept)
        begin
            if (name_closed_reg)
            begin
                // packet already closed: swallow until the end item
                if (name_end)
                begin
                    fill_next        = '0;
                    header_sent_next = 1'b0;
                    name_closed_next = 1'b0;
                    overflow_next    = 1'b0;
                end
            end
            else
            begin
                cq_cmd.hdr       = !header_sent_reg;
                header_sent_next = 1'b1;
                if (name_end)
                begin
                    cq_cmd.lbl       = !fill_zero;
                    cq_cmd.tail      = 1'b1;
                    label_busy_next  = !fill_zero;
                    fill_next        = '0;
                    header_sent_next = 1'b0;
                    name_closed_next = 1'b0;
                    overflow_next    = 1'b0;
                end
                else if (is_dot)
                begin
                    if (fill_zero)
                    begin
                        cq_cmd.tail      = 1'b1;
                        name_closed_next = 1'b1;
                    end
                    else
                    begin
                        cq_cmd.lbl      = 1'b1;
                        label_busy_next = 1'b1;
                        fill_next       = '0;
                    end
                end
                else if (fill_reg < FILL_W'(MAX_LABEL))
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    overflow_next = 1'b1;
                end
            end
        end
    end

    assign cq_wr = accept && (cq_cmd.hdr || cq_cmd.lbl || cq_cmd.tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            header_sent_reg <= 1'b0;
            name_closed_reg <= 1'b0;
            overflow_reg    <= 1'b0;
            label_busy_reg  <= 1'b0;
        end
        else
        begin
            fill_reg        <= fill_next;
            header_sent_reg <= header_sent_next;
            name_closed_reg <= name_closed_next;
            overflow_reg    <= overflow_next;
            label_busy_reg  <= label_busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dqpb_back.sv =====
// Back end: sequences header, label and tail bytes into the output register.
`default_nettype none

module dqpb_back
    import dqpb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              cq_empty,
    output logic                   cq_rd,
    input  wire cmd_t              cq_cmd,
    output logic                   ram_re,
    output logic [LBL_AW-1:0]      ram_raddr,
    input  wire logic [7:0]        ram_rdata,
    output logic                   label_done,
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             packet_byte,
    output logic                   packet_last,
    output logic                   label_truncated
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LEN,
        ST_RD,
        ST_DAT,
        ST_TAIL
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_trunc_reg, out_trunc_next;
    logic             can_load;
    logic             load;
    logic [7:0]       load_byte;
    logic             load_last;

    function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx, input cfg_t c);
        logic [7:0] b;
        begin
            case (idx)
                CNT_W'(0): b = c.query_id[15:8];
                CNT_W'(1): b = c.query_id[7:0];
                CNT_W'(2): b = {7'd0, c.recursion_desired};
                CNT_W'(5): b = 8'd1;   // question count low byte
                default:   b = 8'd0;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] tail_byte(input logic [CNT_W-1:0] idx, input cfg_t c);
        logic [7:0] b;
        begin
            case (idx)
                CNT_W'(1): b = c.query_type[15:8];
                CNT_W'(2): b = c.query_type[7:0];
                CNT_W'(3): b = c.query_class[15:8];
                CNT_W'(4): b = c.query_class[7:0];
                default:   b = 8'd0;   // root label terminator
            endcase
            return b;
        end
    endfunction

    assign can_load  = !out_valid_reg || pop;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign ram_raddr = cnt_reg[LBL_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        cq_rd      = 1'b0;
        ram_re     = 1'b0;
        label_done = 1'b0;
        load       = 1'b0;
        load_byte  = 8'd0;
        load_last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cq_empty)
                begin
                    cq_rd    = 1'b1;
                    cmd_next = cq_cmd;
                    cnt_next = '0;
                    if (cq_cmd.hdr)
                    begin
                        state_next = ST_HDR;
                    end
                    else if (cq_cmd.lbl)
                    begin
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_HDR:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    load_byte = hdr_byte(cnt_reg, cfg);
                    if (cnt_reg == CNT_W'(HDR_LEN - 1))
                    begin
                        cnt_next = '0;
                        if (cmd_reg.lbl)
                        begin
                            state_next = ST_LEN;
                        end
                        else if (cmd_reg.tail)
                        begin
                            state_next = ST_TAIL;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_LEN:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    load_byte  = 8'(cmd_reg.len);
                    cnt_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_DAT;
            end
            ST_DAT:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    load_byte = ram_rdata;
                    if (cnt_inc == CNT_W'(cmd_reg.len))
                    begin
                        label_done = 1'b1;
                        cnt_next   = '0;
                        state_next = cmd_reg.tail ? ST_TAIL : ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        state_next = ST_RD;
                    end
                end
            end
            ST_TAIL:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    load_byte = tail_byte(cnt_reg, cfg);
                    if (cnt_reg == CNT_W'(TAIL_LEN - 1))
                    begin
                        load_last  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = load_byte;
            out_last_next  = load_last;
            out_trunc_next = cmd_reg.trunc;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
            out_trunc_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_trunc_reg <= out_trunc_next;
        end
    end

    assign empty           = !out_valid_reg;
    assign packet_byte     = out_byte_reg;
    assign packet_last     = out_last_reg;
    assign label_truncated = out_trunc_reg;

`ifndef SYNTHESIS
    a_dat_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DAT |-> $past(state_reg) == ST_RD || $past(state_reg) == ST_DAT)
        else $error("label byte taken without a buffer read");

    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HDR |-> cnt_reg < CNT_W'(HDR_LEN))
        else $error("header counter out of range");

    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> cnt_reg < CNT_W'(cmd_reg.len))
        else $error("label read beyond its length");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (load && state_reg == ST_TAIL && cnt_reg == CNT_W'(TAIL_LEN - 1))
        |=> out_valid_reg && out_last_reg)
        else $error("final class byte not marked last");
`endif

endmodule

`default_nettype wire

// ===== rtl/dns_query_packet_builder_unit.sv =====
// Top level of the DNS query packet builder: register port and block wiring.
`default_nettype none

// The block turns a dotted domain name, one character per request, into a DNS
// query packet, one byte per result request, in wire order. The first request
// of a packet emits the 12-byte header; each label is held in a 58-byte buffer
// and emitted as a length byte plus its characters on a dot or on the end
// request; the end adds the root zero byte, query type and class, with
// packet_last on the class low byte. An empty label closes the name early and
// later characters are dropped until the end request. Over-long labels are cut
// and label_truncated stays high for the rest of that packet.
// Timing: a front end takes one request per cycle unless full is high, and
// passes commands through a four-entry queue to a back end that loads one
// byte per cycle into a single output register while that register is free
// or popped, except label characters, each of which needs a buffer read
// state before its load state because the label buffer has a registered
// read port. While a finished label is still being read out, full stays
// high. The back end also spends an idle state fetching each command from
// the queue. Registers at byte addresses 0, 4, 8, 12: query_id,
// recursion_desired, query_type, query_class; write them only while idle.
module dns_query_packet_builder_unit
    import dqpb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // name characters
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        name_char,
    input  wire logic              name_end,
    // packet bytes
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             packet_byte,
    output logic                   packet_last,
    output logic                   label_truncated
);

    cfg_t              cfg_reg;
    logic              cfg_wr;
    logic [1:0]        reg_idx;

    logic              label_done;
    logic              ram_we;
    logic [LBL_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [LBL_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic              cq_wr;
    cmd_t              cq_wr_cmd;
    logic              cq_full;
    logic              cq_rd;
    cmd_t              cq_rd_cmd;
    logic              cq_empty;

    // register port: pready is always high, word-addressed by paddr[3:2]
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.query_id          <= QUERY_ID_RST;
            cfg_reg.recursion_desired <= RD_RST;
            cfg_reg.query_type        <= QUERY_TYPE_RST;
            cfg_reg.query_class       <= QUERY_CLASS_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_QUERY_ID:          cfg_reg.query_id          <= pwdata[15:0];
                REG_RECURSION_DESIRED: cfg_reg.recursion_desired <= pwdata[0];
                REG_QUERY_TYPE:        cfg_reg.query_type        <= pwdata[15:0];
                REG_QUERY_CLASS:       cfg_reg.query_class       <= pwdata[15:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_QUERY_ID:          prdata = {16'd0, cfg_reg.query_id};
            REG_RECURSION_DESIRED: prdata = {31'd0, cfg_reg.recursion_desired};
            REG_QUERY_TYPE:        prdata = {16'd0, cfg_reg.query_type};
            REG_QUERY_CLASS:       prdata = {16'd0, cfg_reg.query_class};
            default:               prdata = 32'd0;
        endcase
    end

    dqpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .name_char  (name_char),
        .name_end   (name_end),
        .label_done (label_done),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .cq_wr      (cq_wr),
        .cq_cmd     (cq_wr_cmd),
        .cq_full    (cq_full)
    );

    // label buffer
    dqpb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LABEL)
    ) u_label_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dqpb_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cq_wr),
        .wr_cmd (cq_wr_cmd),
        .full   (cq_full),
        .rd_en  (cq_rd),
        .rd_cmd (cq_rd_cmd),
        .empty  (cq_empty)
    );

    dqpb_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cq_empty        (cq_empty),
        .cq_rd           (cq_rd),
        .cq_cmd          (cq_rd_cmd),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .label_done      (label_done),
        .empty           (empty),
        .pop             (pop),
        .packet_byte     (packet_byte),
        .packet_last     (packet_last),
        .label_truncated (label_truncated)
    );

endmodule

`default_nettype wire

// ===== verif/dns_query_packet_builder_unit_tb.sv =====
// Self-checking testbench for the DNS query packet builder: directed table, then random names.
`default_nettype none

module dns_query_packet_builder_unit_tb;
    import dqpb_pkg::*;

    // run control
    localparam int CYCLE_LIMIT = 600000;  // far above the slowest correct run
    localparam int SETTLE      = 12;      // buffered characters may still be in flight
    localparam int DRAIN_TAIL  = 150;     // watch for stray bytes after the last one
    localparam int PRINT_CAP   = 40;
    localparam int LIT_MAX     = 17;      // longest typed-in expectation: header plus tail

    // bytes read straight off the packet format under reset register values
    localparam logic [95:0]  HDR_DFLT  = 96'h04D2_0100_0001_0000_0000_0000;
    localparam logic [39:0]  TAIL_DFLT = 40'h00_0001_0001;
    localparam logic [135:0] PKT_DFLT  = {HDR_DFLT, TAIL_DFLT};

    // one name request; lit_n > 0 means the expected bytes are typed in, right-aligned in lit
    typedef struct packed {
        logic [7:0]             ch;
        logic                   fin;
        logic [4:0]             lit_n;
        logic                   lit_last;
        logic [8*LIT_MAX-1:0]   lit;
    } name_req_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       cut;
    } pkt_byte_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              push;
    logic              full;
    logic [7:0]        name_char;
    logic              name_end;
    logic              empty;
    logic              pop;
    logic [7:0]        packet_byte;
    logic              packet_last;
    logic              label_truncated;

    dns_query_packet_builder_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .name_char       (name_char),
        .name_end        (name_end),
        .empty           (empty),
        .pop             (pop),
        .packet_byte     (packet_byte),
        .packet_last     (packet_last),
        .label_truncated (label_truncated)
    );

    // ------------------------------------------------------------------
    // Packet predictor: own copy of the builder state and the registers
    // ------------------------------------------------------------------
    logic [15:0] cfg_id;
    logic        cfg_rd;
    logic [15:0] cfg_type;
    logic [15:0] cfg_class;

    logic [7:0]  lbl_buf [MAX_LABEL];
    int          lbl_len;
    bit          hdr_done;
    bit          name_done;    // empty label seen: rest of the name is dropped
    bit          cut_flag;     // some label of this packet lost characters

    pkt_byte_t   step_bytes [$];   // bytes caused by the request just taken
    pkt_byte_t   bytes_due [$];    // bytes still owed by the block, oldest first

    // truncation flag is the one in force when the byte goes out
    function automatic void put_byte(input logic [7:0] b, input logic last);
        pkt_byte_t pb;
        pb.data = b;
        pb.last = last;
        pb.cut  = cut_flag;
        step_bytes.push_back(pb);
    endfunction

    function automatic void flush_label();
        put_byte(8'(lbl_len), 1'b0);
        for (int k = 0; k < lbl_len; k++)
            put_byte(lbl_buf[k], 1'b0);
        lbl_len = 0;
    endfunction

    // root zero byte, type, class; last mark on the class low byte
    function automatic void put_tail();
        put_byte(8'h00, 1'b0);
        put_byte(cfg_type[15:8], 1'b0);
        put_byte(cfg_type[7:0], 1'b0);
        put_byte(cfg_class[15:8], 1'b0);
        put_byte(cfg_class[7:0], 1'b1);
    endfunction

    function automatic void rearm_builder();
        lbl_len   = 0;
        hdr_done  = 1'b0;
        name_done = 1'b0;
        cut_flag  = 1'b0;
    endfunction

    function automatic void step_builder(input logic [7:0] ch, input logic fin);
        step_bytes.delete();
        if (name_done) begin
            // closed name: only an end request has an effect, and it is silent
            if (fin)
                rearm_builder();
            return;
        end
        if (!hdr_done) begin
            put_byte(cfg_id[15:8], 1'b0);
            put_byte(cfg_id[7:0], 1'b0);
            put_byte({7'd0, cfg_rd}, 1'b0);
            put_byte(8'h00, 1'b0);
            put_byte(8'h00, 1'b0);     // question count, big-endian one
            put_byte(8'h01, 1'b0);
            for (int k = 0; k < 6; k++)
                put_byte(8'h00, 1'b0);
            hdr_done = 1'b1;
        end
        if (fin) begin
            if (lbl_len > 0)
                flush_label();
            put_tail();
            rearm_builder();
        end else if (ch == DOT_CHAR) begin
            if (lbl_len == 0) begin
                // empty label ends the name early
                put_tail();
                name_done = 1'b1;
            end else begin
                flush_label();
            end
        end else if (lbl_len < MAX_LABEL) begin
            lbl_buf[lbl_len] = ch;
            lbl_len++;
        end else begin
            cut_flag = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    int cycles;
    int faults;
    int snd_idle_pct;
    int rcv_idle_pct;
    int live_items;    // requests that the block acted on (closed-name noise not counted)
    bit long_done;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: no progress, cycle limit reached", $time);
            $display("** dns_query_packet_builder_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random pop, compare each taken byte with the oldest one owed
    // ------------------------------------------------------------------
    pkt_byte_t got_byte;
    pkt_byte_t want_byte;

    task automatic flag_fault(input string what, input int want, input int got);
        faults++;
        if (faults <= PRINT_CAP)
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            got_byte.data = packet_byte;
            got_byte.last = packet_last;
            got_byte.cut  = label_truncated;
            if (bytes_due.size() == 0) begin
                flag_fault("unexpected byte, expected none", 0, got_byte.data);
            end else begin
                want_byte = bytes_due.pop_front();
                if (got_byte.data !== want_byte.data)
                    flag_fault("packet_byte", want_byte.data, got_byte.data);
                if (got_byte.last !== want_byte.last)
                    flag_fault("packet_last", want_byte.last, got_byte.last);
                if (got_byte.cut !== want_byte.cut)
                    flag_fault("label_truncated", want_byte.cut, got_byte.cut);
            end
        end
        pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request; it is taken at the first edge with full low. A gap, if
    // any, drops push first, so push is never lowered and raised in one step.
    task automatic send_req(input name_req_t r);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push      <= 1'b1;
        name_char <= r.ch;
        name_end  <= r.fin;
        do @(posedge clk); while (full);
        if (!name_done)
            live_items++;
        step_builder(r.ch, r.fin);
        if (r.lit_n != 0) begin
            for (int k = 0; k < int'(r.lit_n); k++) begin
                want_byte.data = r.lit[8*(int'(r.lit_n)-1-k) +: 8];
                want_byte.last = r.lit_last && (k == int'(r.lit_n) - 1);
                want_byte.cut  = 1'b0;
                bytes_due.push_back(want_byte);
            end
        end else begin
            foreach (step_bytes[k])
                bytes_due.push_back(step_bytes[k]);
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic fin);
        name_req_t r;
        r       = '0;
        r.ch    = ch;
        r.fin   = fin;
        send_req(r);
    endtask

    // Stop offering until every owed byte has come, then let the block settle.
    task automatic drain();
        push <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; junk above the register width
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_QUERY_ID:          cfg_id    = val;
            REG_RECURSION_DESIRED: cfg_rd    = val[0];
            REG_QUERY_TYPE:        cfg_type  = val;
            REG_QUERY_CLASS:       cfg_class = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] id, input logic [15:0] rd,
                                 input logic [15:0] typ, input logic [15:0] cls);
        cfg_write(REG_QUERY_ID, id);
        cfg_write(REG_RECURSION_DESIRED, rd);
        cfg_write(REG_QUERY_TYPE, typ);
        cfg_write(REG_QUERY_CLASS, cls);
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == DOT_CHAR);
        return c;
    endfunction

    // Mostly well-formed names with random content; some end on an empty label
    // followed by junk, and a tenth are raw noise with dots and ends anywhere.
    task automatic send_random_name();
        int kind;
        int nlab;
        int len;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(4, 12))
                send_char(($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom),
                          ($urandom_range(0, 7) == 0));
            return;
        end
        nlab = $urandom_range(1, 4);
        for (int l = 0; l < nlab; l++) begin
            // long labels straddle the buffer size: exact fit and overflow
            if (!long_done || $urandom_range(0, 19) == 0) begin
                len       = $urandom_range(MAX_LABEL - 1, MAX_LABEL + 4);
                long_done = 1'b1;
            end else begin
                len = $urandom_range(1, 8);
            end
            repeat (len)
                send_char(label_char(), 1'b0);
            if (l < nlab - 1)
                send_char(DOT_CHAR, 1'b0);
        end
        if (kind == 1) begin
            // trailing dot leaves an empty label, then dropped junk
            send_char(DOT_CHAR, 1'b0);
            repeat ($urandom_range(0, 3))
                send_char(($urandom_range(0, 2) == 0) ? DOT_CHAR : 8'($urandom), 1'b0);
        end
        send_char(8'($urandom), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Directed table: reset values, so header and tail can be typed in
    // ------------------------------------------------------------------
    name_req_t dir_reqs [15] = '{
        '{8'h00, 1'b1, 5'd17, 1'b1, PKT_DFLT},          // end as the very first request
        '{8'h61, 1'b0, 5'd12, 1'b0, 136'(HDR_DFLT)},    // first character brings the header
        '{8'h00, 1'b0, 5'd0,  1'b0, 136'd0},            // zero byte is a plain character
        '{8'hFF, 1'b0, 5'd0,  1'b0, 136'd0},
        '{DOT_CHAR, 1'b0, 5'd0, 1'b0, 136'd0},          // label of three
        '{DOT_CHAR, 1'b0, 5'd5, 1'b1, 136'(TAIL_DFLT)}, // empty label closes the name
        '{8'h78, 1'b0, 5'd0,  1'b0, 136'd0},            // dropped after close
        '{DOT_CHAR, 1'b0, 5'd0, 1'b0, 136'd0},          // dropped after close
        '{DOT_CHAR, 1'b1, 5'd0, 1'b0, 136'd0},          // silent end rearms, char ignored
        '{DOT_CHAR, 1'b0, 5'd17, 1'b1, PKT_DFLT},       // dot as first request
        '{8'hFF, 1'b1, 5'd0,  1'b0, 136'd0},            // silent end again
        '{8'h77, 1'b0, 5'd0,  1'b0, 136'd0},
        '{8'h77, 1'b0, 5'd0,  1'b0, 136'd0},
        '{DOT_CHAR, 1'b0, 5'd0, 1'b0, 136'd0},
        '{8'h63, 1'b0, 5'd0,  1'b0, 136'd0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        push         = 1'b0;
        name_char    = '0;
        name_end     = 1'b0;
        pop          = 1'b0;
        cycles       = 0;
        faults       = 0;
        live_items   = 0;
        long_done    = 1'b0;
        snd_idle_pct = 16;
        rcv_idle_pct = 45;

        cfg_id    = QUERY_ID_RST;
        cfg_rd    = RD_RST;
        cfg_type  = QUERY_TYPE_RST;
        cfg_class = QUERY_CLASS_RST;
        foreach (lbl_buf[k])
            lbl_buf[k] = 8'h00;
        rearm_builder();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_reqs[k])
            send_req(dir_reqs[k]);

        // register change in the middle of a packet: the tail picks up the new type
        drain();
        cfg_write(REG_QUERY_TYPE, 16'h001C);
        send_char(DOT_CHAR, 1'b1);

        // three random phases: zero registers, all-ones registers, random registers
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: load_settings(16'h0000, {15'($urandom), 1'b0}, 16'h0000, 16'h0000);
                1: load_settings(16'hFFFF, {15'($urandom), 1'b1}, 16'hFFFF, 16'hFFFF);
                default: load_settings(16'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom));
            endcase
            case (ph)
                0: begin snd_idle_pct = 16; rcv_idle_pct = 45; end
                1: begin snd_idle_pct = 45; rcv_idle_pct = 16; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            while (live_items < 16 + 68 * (ph + 1)) begin
                send_random_name();
                // now and then hold off until the block has caught up
                if ($urandom_range(0, 29) == 0)
                    drain();
            end
        end

        push <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (faults == 0)
            $display("** dns_query_packet_builder_unit: PASSED **");
        else
            $display("** dns_query_packet_builder_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
